>>> rtl/fasta_index_scanner_macros.svh
// assertion macros used by the top-level block to check itself
`ifndef FASTA_INDEX_SCANNER_MACROS_SVH
`define FASTA_INDEX_SCANNER_MACROS_SVH

// same-cycle implication, off during reset
`define FIS_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, off during reset
`define FIS_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> rtl/fis_pkg.sv
package fis_pkg;

   // counter width and saturation limit
   localparam int COUNT_BITS = 40;
   typedef logic [COUNT_BITS-1:0] count_type;
   localparam count_type COUNT_MAX = '1;

   // characters the parser looks for
   localparam logic [7:0] CHAR_GT      = 8'h3E;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   // input action codes
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   // result kind codes
   localparam logic KIND_NAME   = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   // parser phases
   typedef enum logic [2:0] {
      PH_FIRST,
      PH_NAME,
      PH_DESC,
      PH_SEQ,
      PH_IGNORE
   } phase_type;

   // one input item
   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } item_type;

   // one result item
   typedef struct packed {
      logic       result_kind;
      logic [7:0] name_byte;
      count_type  sequence_length;
      count_type  sequence_offset;
      count_type  first_line_bases;
      count_type  first_line_bytes;
      logic       final_result;
   } result_type;

   // parser output toward the result register
   typedef struct packed {
      logic       valid;
      result_type data;
   } result_slot_type;

   // saturating increment
   function automatic count_type sat_inc(input count_type v);
      return (v == COUNT_MAX) ? v : v + count_type'(1);
   endfunction

endpackage

>>> rtl/fis_if.sv
// input channel: one file byte or end of input per transfer
interface fis_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink (input valid, action, data_byte, output ready);
endinterface

// result channel: a name byte or a contig record per transfer
interface fis_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [7:0]         name_byte;
   fis_pkg::count_type sequence_length;
   fis_pkg::count_type sequence_offset;
   fis_pkg::count_type first_line_bases;
   fis_pkg::count_type first_line_bytes;
   logic               final_result;

   modport source (output valid, result_kind, name_byte, sequence_length, sequence_offset,
                   first_line_bases, first_line_bytes, final_result, input ready);
   modport sink (input valid, result_kind, name_byte, sequence_length, sequence_offset,
                 first_line_bases, first_line_bytes, final_result, output ready);
endinterface

>>> rtl/fis_in_stage.sv
module fis_in_stage (
   input  logic              clock,
   input  logic              reset,
   fis_req_if.sink           req_bus,
   input  logic              take,
   output logic              held_valid,
   output fis_pkg::item_type held_item
);

   logic              valid_ff;
   logic              valid_in;
   fis_pkg::item_type item_ff;
   logic              load;

   // room when empty or when the held item moves on this cycle
   assign req_bus.ready = !valid_ff || take;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture on transfer
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.action    <= req_bus.action;
         item_ff.data_byte <= req_bus.data_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

>>> rtl/fis_parser.sv
module fis_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  fis_pkg::item_type        item,
   output fis_pkg::result_slot_type result
);

   fis_pkg::phase_type phase_ff, phase_in;
   fis_pkg::count_type position_ff, position_in;
   fis_pkg::count_type bases_ff, bases_in;
   fis_pkg::count_type start_ff, start_in;
   fis_pkg::count_type line_bases_ff, line_bases_in;
   fis_pkg::count_type line_bytes_ff, line_bytes_in;
   logic               line_open_ff, line_open_in;
   fis_pkg::result_type record;

   // record built from the current contig counters
   always_comb begin
      record                  = '0;
      record.result_kind      = fis_pkg::KIND_RECORD;
      record.sequence_length  = bases_ff;
      record.sequence_offset  = start_ff;
      record.first_line_bases = line_open_ff ? '0 : line_bases_ff;
      record.first_line_bytes = line_open_ff ? '0 : line_bytes_ff;
   end

   // next state and result
   always_comb begin
      phase_in      = phase_ff;
      position_in   = fis_pkg::sat_inc(position_ff);
      bases_in      = bases_ff;
      start_in      = start_ff;
      line_bases_in = line_bases_ff;
      line_bytes_in = line_bytes_ff;
      line_open_in  = line_open_ff;
      result        = '0;

      if (item.action == fis_pkg::ACTION_END) begin
         // end of input: close the open contig, back to reset state
         if (phase_ff == fis_pkg::PH_NAME || phase_ff == fis_pkg::PH_DESC) begin
            result.valid                  = 1'b1;
            result.data.result_kind       = fis_pkg::KIND_RECORD;
            result.data.final_result      = 1'b1;
         end else if (phase_ff == fis_pkg::PH_SEQ) begin
            result.valid                  = 1'b1;
            result.data                   = record;
            result.data.final_result      = 1'b1;
         end
         phase_in      = fis_pkg::PH_FIRST;
         position_in   = '0;
         bases_in      = '0;
         start_in      = '0;
         line_bases_in = '0;
         line_bytes_in = '0;
         line_open_in  = 1'b1;
      end else begin
         unique case (phase_ff)
            fis_pkg::PH_FIRST: begin
               phase_in = (item.data_byte == fis_pkg::CHAR_GT) ? fis_pkg::PH_NAME
                                                               : fis_pkg::PH_IGNORE;
            end
            fis_pkg::PH_NAME: begin
               if (item.data_byte == fis_pkg::CHAR_SPACE) begin
                  phase_in = fis_pkg::PH_DESC;
               end else if (item.data_byte == fis_pkg::CHAR_NEWLINE) begin
                  phase_in = fis_pkg::PH_SEQ;
                  start_in = fis_pkg::sat_inc(position_ff);
               end else begin
                  result.valid            = 1'b1;
                  result.data.result_kind = fis_pkg::KIND_NAME;
                  result.data.name_byte   = item.data_byte;
               end
            end
            fis_pkg::PH_DESC: begin
               if (item.data_byte == fis_pkg::CHAR_NEWLINE) begin
                  phase_in = fis_pkg::PH_SEQ;
                  start_in = fis_pkg::sat_inc(position_ff);
               end
            end
            fis_pkg::PH_SEQ: begin
               if (item.data_byte == fis_pkg::CHAR_NEWLINE) begin
                  if (line_open_ff) begin
                     line_bytes_in = fis_pkg::sat_inc(line_bytes_ff);
                     line_open_in  = 1'b0;
                  end
               end else if (item.data_byte == fis_pkg::CHAR_GT) begin
                  // next header closes this contig
                  result.valid  = 1'b1;
                  result.data   = record;
                  phase_in      = fis_pkg::PH_NAME;
                  bases_in      = '0;
                  start_in      = '0;
                  line_bases_in = '0;
                  line_bytes_in = '0;
                  line_open_in  = 1'b1;
               end else begin
                  if (line_open_ff) begin
                     line_bases_in = fis_pkg::sat_inc(line_bases_ff);
                     line_bytes_in = fis_pkg::sat_inc(line_bytes_ff);
                  end
                  bases_in = fis_pkg::sat_inc(bases_ff);
               end
            end
            default: begin
               phase_in = fis_pkg::PH_IGNORE;
            end
         endcase
      end

      if (!step) begin
         result.valid = 1'b0;
      end
   end

   // state register, advanced once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= fis_pkg::PH_FIRST;
         position_ff   <= '0;
         bases_ff      <= '0;
         start_ff      <= '0;
         line_bases_ff <= '0;
         line_bytes_ff <= '0;
         line_open_ff  <= 1'b1;
      end else if (step) begin
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         bases_ff      <= bases_in;
         start_ff      <= start_in;
         line_bases_ff <= line_bases_in;
         line_bytes_ff <= line_bytes_in;
         line_open_ff  <= line_open_in;
      end
   end

endmodule

>>> rtl/fis_rsp_stage.sv
module fis_rsp_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  fis_pkg::result_slot_type load,
   output logic                     free,
   fis_rsp_if.source                rsp_bus
);

   logic                valid_ff;
   logic                valid_in;
   fis_pkg::result_type data_ff;

   // empty, or the held result leaves this cycle
   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result capture
   always_ff @(posedge clock) begin
      if (free && load.valid) begin
         data_ff <= load.data;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.result_kind      = data_ff.result_kind;
   assign rsp_bus.name_byte        = data_ff.name_byte;
   assign rsp_bus.sequence_length  = data_ff.sequence_length;
   assign rsp_bus.sequence_offset  = data_ff.sequence_offset;
   assign rsp_bus.first_line_bases = data_ff.first_line_bases;
   assign rsp_bus.first_line_bytes = data_ff.first_line_bytes;
   assign rsp_bus.final_result     = data_ff.final_result;

endmodule

>>> rtl/fasta_index_scanner.sv
// FASTA index scanner. Send a FASTA file one byte per transfer, then one end-of-input
// transfer. For each contig the block returns its name bytes (header text after '>' up to
// the first space or newline), then a record with the base count, the file offset of the
// first base and the bases and bytes of the first sequence line; the record given at end
// of input carries final_result. A file not starting with '>' gives no results. Counters
// saturate at all ones. The block takes one item per clock cycle; an item is held in the input
// stage and its result in the result register. Throughput is set by the result register: while a
// result waits on rsp_bus.ready, one more item is held at the input and then req_bus.ready
// drops until the result is taken.
`include "fasta_index_scanner_macros.svh"

module fasta_index_scanner (
   input  logic      clock,
   input  logic      reset,
   fis_req_if.sink   req_bus,
   fis_rsp_if.source rsp_bus
);

   logic                     held_valid;
   fis_pkg::item_type        held_item;
   logic                     rsp_free;
   logic                     step;
   fis_pkg::result_slot_type result;

   // the held item is processed when the result register can take its outcome
   assign step = held_valid && rsp_free;

   fis_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (step),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   fis_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (held_item),
      .result (result)
   );

   fis_rsp_stage u_rsp_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (result),
      .free    (rsp_free),
      .rsp_bus (rsp_bus)
   );

   // checks on the block's own logic
   `FIS_ASSERT_NOW(a_ready_only_when_held, clock, reset, !req_bus.ready, held_valid, "input stalled with no held item")
   `FIS_ASSERT_NOW(a_final_is_record, clock, reset, rsp_bus.valid && rsp_bus.final_result, rsp_bus.result_kind == fis_pkg::KIND_RECORD, "final flag on a name byte")
   `FIS_ASSERT_NOW(a_name_has_no_counts, clock, reset, rsp_bus.valid && rsp_bus.result_kind == fis_pkg::KIND_NAME, rsp_bus.sequence_length == '0 && rsp_bus.sequence_offset == '0, "name byte carries counts")
   `FIS_ASSERT_NEXT(a_result_register_fill, clock, reset, step && result.valid, rsp_bus.valid, "processed result not held")

endmodule

>>> tb/tb_fasta_index_scanner.sv
`timescale 1ns / 1ps

module tb_fasta_index_scanner;

   // predicts name bytes and contig records from the accepted byte stream
   class contig_index_scoreboard;
      fis_pkg::phase_type  phase;
      fis_pkg::count_type  byte_pos;
      fis_pkg::count_type  base_total;
      fis_pkg::count_type  first_base_pos;
      fis_pkg::count_type  line_bases;
      fis_pkg::count_type  line_len;
      bit                  line_open;
      fis_pkg::result_type expected_q[$];
      int                  error_count;

      function new();
         error_count = 0;
         restart();
      endfunction

      function void clear_contig();
         base_total     = '0;
         first_base_pos = '0;
         line_bases     = '0;
         line_len       = '0;
         line_open      = 1'b1;
      endfunction

      function void restart();
         phase    = fis_pkg::PH_FIRST;
         byte_pos = '0;
         clear_contig();
      endfunction

      // counters stick at all ones
      function fis_pkg::count_type bump(fis_pkg::count_type v);
         return (&v) ? v : v + fis_pkg::count_type'(1);
      endfunction

      function void push_record(bit counted, bit closing);
         fis_pkg::result_type r;
         r = '0;
         r.result_kind = fis_pkg::KIND_RECORD;
         if (counted) begin
            r.sequence_length = base_total;
            r.sequence_offset = first_base_pos;
            if (!line_open) begin
               r.first_line_bases = line_bases;
               r.first_line_bytes = line_len;
            end
         end
         r.final_result = closing;
         expected_q = {expected_q, r};
      endfunction

      // note an accepted transfer on the input side
      function void note_item(fis_pkg::item_type it);
         fis_pkg::result_type r;
         if (it.action == fis_pkg::ACTION_END) begin
            if (phase == fis_pkg::PH_NAME || phase == fis_pkg::PH_DESC) begin
               push_record(1'b0, 1'b1);
            end else if (phase == fis_pkg::PH_SEQ) begin
               push_record(1'b1, 1'b1);
            end
            restart();
            return;
         end
         case (phase)
            fis_pkg::PH_FIRST: begin
               if (it.data_byte == fis_pkg::CHAR_GT) phase = fis_pkg::PH_NAME;
               else phase = fis_pkg::PH_IGNORE;
            end
            fis_pkg::PH_NAME: begin
               if (it.data_byte == fis_pkg::CHAR_SPACE) begin
                  phase = fis_pkg::PH_DESC;
               end else if (it.data_byte == fis_pkg::CHAR_NEWLINE) begin
                  phase = fis_pkg::PH_SEQ;
                  first_base_pos = bump(byte_pos);
               end else begin
                  r = '0;
                  r.result_kind = fis_pkg::KIND_NAME;
                  r.name_byte = it.data_byte;
                  expected_q = {expected_q, r};
               end
            end
            fis_pkg::PH_DESC: begin
               if (it.data_byte == fis_pkg::CHAR_NEWLINE) begin
                  phase = fis_pkg::PH_SEQ;
                  first_base_pos = bump(byte_pos);
               end
            end
            fis_pkg::PH_SEQ: begin
               if (it.data_byte == fis_pkg::CHAR_NEWLINE) begin
                  if (line_open) begin
                     line_len = bump(line_len);
                     line_open = 1'b0;
                  end
               end else if (it.data_byte == fis_pkg::CHAR_GT) begin
                  push_record(1'b1, 1'b0);
                  clear_contig();
                  phase = fis_pkg::PH_NAME;
               end else begin
                  if (line_open) begin
                     line_bases = bump(line_bases);
                     line_len = bump(line_len);
                  end
                  base_total = bump(base_total);
               end
            end
            default: phase = fis_pkg::PH_IGNORE;
         endcase
         byte_pos = bump(byte_pos);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
         end
      endfunction

      // check a result transfer against the oldest prediction
      function void check_result(fis_pkg::result_type got);
         fis_pkg::result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
         compare_field("name_byte", 64'(want.name_byte), 64'(got.name_byte));
         compare_field("sequence_length", 64'(want.sequence_length),
                       64'(got.sequence_length));
         compare_field("sequence_offset", 64'(want.sequence_offset),
                       64'(got.sequence_offset));
         compare_field("first_line_bases", 64'(want.first_line_bases),
                       64'(got.first_line_bases));
         compare_field("first_line_bytes", 64'(want.first_line_bytes),
                       64'(got.first_line_bytes));
         compare_field("final_result", 64'(want.final_result), 64'(got.final_result));
      endfunction
   endclass

   logic clock;
   logic reset;

   fis_req_if req_bus();
   fis_rsp_if rsp_bus();

   fasta_index_scanner u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   contig_index_scoreboard sb;
   int          burst_left = 0;
   int          useful_items = 0;
   bit          ignored_file = 1'b0;
   int unsigned rx_cycle = 0;
   int unsigned hold_left = 0;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run limit
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // one input transfer, with bursts and gaps on the sender side
   task automatic send_item(input logic act, input logic [7:0] value);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 12)) @(posedge clock);
         else repeat ($urandom_range(1, 3)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.data_byte <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (!ignored_file) useful_items++;
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_item(fis_pkg::ACTION_BYTE, value);
   endtask

   // end of input; the byte lane carries junk
   task automatic send_end();
      send_item(fis_pkg::ACTION_END, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // one random file: mostly well-formed contigs, some junk and cut-off streams
   task automatic send_random_file();
      int         kind;
      int         contigs;
      int         lines;
      int         ci;
      int         li;
      logic [7:0] b;
      string      acgt;
      acgt = "ACGT";
      kind = $urandom_range(0, 19);
      ignored_file = (kind <= 1);
      if (kind == 0) begin
         // junk that does not start with '>'
         b = 8'($urandom_range(0, 255));
         if (b == fis_pkg::CHAR_GT) b = b ^ 8'h01;
         send_byte(b);
         repeat ($urandom_range(0, 15)) send_byte(8'($urandom_range(0, 255)));
         send_end();
         ignored_file = 1'b0;
         return;
      end
      if (kind == 1) begin
         send_end();
         ignored_file = 1'b0;
         return;
      end
      contigs = $urandom_range(1, 3);
      for (ci = 0; ci < contigs; ci++) begin
         send_byte(fis_pkg::CHAR_GT);
         // name bytes, anything but the two separators
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == fis_pkg::CHAR_SPACE || b == fis_pkg::CHAR_NEWLINE) b = 8'h5F;
            send_byte(b);
         end
         // optional description, may hold spaces and '>'
         if ($urandom_range(0, 1) == 1) begin
            send_byte(fis_pkg::CHAR_SPACE);
            repeat ($urandom_range(0, 8)) begin
               b = 8'($urandom_range(0, 255));
               if (b == fis_pkg::CHAR_NEWLINE) b = fis_pkg::CHAR_GT;
               send_byte(b);
            end
         end
         // cut-off stream ends inside the header
         if (kind <= 3 && ci == contigs - 1) begin
            send_end();
            return;
         end
         send_byte(fis_pkg::CHAR_NEWLINE);
         lines = $urandom_range(0, 4);
         for (li = 0; li < lines; li++) begin
            repeat ($urandom_range(0, 12)) begin
               if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
               else b = acgt[$urandom_range(0, 3)];
               if (b == fis_pkg::CHAR_NEWLINE || b == fis_pkg::CHAR_GT) b = 8'h4E;
               send_byte(b);
            end
            if (li < lines - 1 || $urandom_range(0, 2) != 0) send_byte(fis_pkg::CHAR_NEWLINE);
         end
      end
      send_end();
   endtask

   // receiver: changing stall patterns plus long hold-offs that back up the input
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle == 1500 || rx_cycle == 4000) hold_left = 150;
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((rx_cycle >> 8) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ((rx_cycle % 7) >= 2);
               default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // watch both channels
   always @(posedge clock) begin
      fis_pkg::result_type got;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_item(fis_pkg::item_type'{req_bus.action, req_bus.data_byte});
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.result_kind      = rsp_bus.result_kind;
            got.name_byte        = rsp_bus.name_byte;
            got.sequence_length  = rsp_bus.sequence_length;
            got.sequence_offset  = rsp_bus.sequence_offset;
            got.first_line_bases = rsp_bus.first_line_bases;
            got.first_line_bytes = rsp_bus.first_line_bytes;
            got.final_result     = rsp_bus.final_result;
            sb.check_result(got);
         end
      end
   end

   // reset, directed files, random files, drain
   initial begin
      sb = new();
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.action    <= fis_pkg::ACTION_BYTE;
      req_bus.data_byte <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty stream
      send_end();
      // file not starting with '>'
      send_byte(8'hFF);
      send_byte(fis_pkg::CHAR_GT);
      send_end();
      // '>' as a name byte, end inside the name
      send_text(">>x");
      send_end();
      // '>' in the description, header line with no sequence after it
      send_text(">a >d\n");
      send_end();
      // two contigs, the second cut off in its description
      send_byte(fis_pkg::CHAR_GT);
      send_byte(8'h00);
      send_text("\nAC\nG> ");
      send_end();

      while (useful_items < 1800) send_random_file();
      req_bus.valid <= 1'b0;

      // let the monitor note the last transfer before draining
      repeat (2) @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
